@@ hdl/eps_pkg.sv @@
// Shared types, widths and codes for the event period statistics table.
// No dependencies; used by event_period_stats_table.
package eps_pkg;

    localparam int KEY_W         = 56;
    localparam int KEY_BYTES_MAX = 7;
    localparam int TS_W          = 32;
    localparam int CNT32_W       = 32;
    localparam int ACC_W         = 64;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int NAME_BYTES_DEF  = 8;

    // stream payload widths, packed low field first, padded to whole bytes
    localparam int IN_BITS   = KEY_W + 1 + TS_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + 6 * TS_W + 2 * ACC_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_CREATED    = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_QUERY_HIT  = 3'd3,
        ST_QUERY_MISS = 3'd4
    } t_status;

    // one entry of the statistics memory
    typedef struct packed {
        logic [TS_W-1:0]    max_p;
        logic [TS_W-1:0]    min_p;
        logic [ACC_W-1:0]   sq_sum;
        logic [ACC_W-1:0]   sum;
        logic [CNT32_W-1:0] intervals;
        logic [CNT32_W-1:0] updates;
        logic [TS_W-1:0]    last_time;
        logic [TS_W-1:0]    first_time;
        logic               healthy;
    } t_stat_rec;

    // Keep the bytes of a key below n_bytes, up to its first zero byte.
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw,
                                                   input int n_bytes);
        logic [KEY_W-1:0] k;
        logic             stop;
        k    = '0;
        stop = 1'b0;
        for (int b = 0; b < KEY_BYTES_MAX; b++) begin
            if (b >= n_bytes || raw[8*b +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                k[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return k;
    endfunction

endpackage

@@ hdl/event_period_stats_table.sv @@
// Event period statistics table: key search and read-modify-write of entries.
// Depends on eps_pkg (widths, status codes, record type, key canonicalization).
//
// Usage:
//   Slave stream (s_axis_*) carries one command item: tuser is cmd (update or
//   query), tdata holds source_key, healthy_in and event_time. Master stream
//   (m_axis_*) returns exactly one result item per command: tuser is status,
//   tdata holds the entry's statistics (zeros for a query miss or a drop).
//   Keys and statistics records sit in two memories with registered reads. A
//   command scans the keys one entry a cycle and reads the matching record;
//   an update hit squares the period in a registered multiplier, accumulates
//   and writes the record back.
//   One item is in work at a time; s_axis_tready is high only while idle, so
//   the next item is taken no earlier than the cycle after the result is
//   loaded. Reset clears the entry count and handshake state; memories are
//   not cleared, since only entries below the count are ever read. When the
//   receiver stalls, hold the result in the output register and hold the next
//   result before write-back; no new item is accepted meanwhile.
module event_period_stats_table #(
    parameter int MAX_ENTRIES = eps_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_BYTES  = eps_pkg::NAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tuser: cmd
    input  logic                            s_axis_tuser,
    // tdata: source_key[55:0], healthy_in[56], event_time[88:57], zero pad
    input  logic [eps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tuser: status
    output logic [2:0]                      m_axis_tuser,
    // tdata: healthy_out, first_time, last_time, update_count, interval_count,
    //        interval_sum, interval_square_sum, interval_min, interval_max, pad
    output logic [eps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_BYTES = (NAME_BYTES - 1 < eps_pkg::KEY_BYTES_MAX)
                               ? NAME_BYTES - 1 : eps_pkg::KEY_BYTES_MAX;
    localparam int TS_W      = eps_pkg::TS_W;
    localparam int ACC_W     = eps_pkg::ACC_W;
    localparam int KEY_W     = eps_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MISS,
        S_LOAD,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_used;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    eps_pkg::t_cmd           r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic                    r_healthy;
    logic [TS_W-1:0]         r_ts;
    eps_pkg::t_stat_rec      r_rec;
    eps_pkg::t_stat_rec      n_rec;
    logic [TS_W-1:0]         r_period;
    logic                    r_acc;
    logic [ACC_W-1:0]        r_sq;
    eps_pkg::t_status        r_status;
    logic                    r_write;
    logic                    r_create;

    logic                    r_out_valid;
    eps_pkg::t_status        r_out_status;
    eps_pkg::t_stat_rec      r_out_rec;

    // memories: keys and statistics records, registered read
    logic [KEY_W-1:0]        key_mem  [MAX_ENTRIES];
    eps_pkg::t_stat_rec      stat_mem [MAX_ENTRIES];
    logic [KEY_W-1:0]        r_key_q;
    eps_pkg::t_stat_rec      r_stat_q;

    logic                    in_fire;
    logic                    emit_fire;
    logic                    key_hit;
    logic                    scan_last;
    logic                    can_create;
    logic [TS_W-1:0]         period;
    logic                    period_ok;
    logic [ACC_W-1:0]        sq_prod;
    logic                    key_we;
    logic                    stat_we;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign emit_fire  = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);
    assign key_hit    = (r_key_q == r_key);
    assign scan_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_used;
    assign can_create = (r_cmd == eps_pkg::CMD_UPDATE) && (r_used != CNT_W'(MAX_ENTRIES));
    assign period     = r_ts - r_stat_q.last_time;
    assign period_ok  = (r_stat_q.last_time != '0) && (r_ts > r_stat_q.last_time);
    assign sq_prod    = ACC_W'(r_period) * ACC_W'(r_period);
    assign key_we     = emit_fire && r_create;
    assign stat_we    = emit_fire && r_write;

    // read address: start of scan, next entry, new slot, or hold on a hit
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_IDLE) begin
            n_idx = '0;
        end else if (r_state == S_SEARCH && !key_hit && !scan_last) begin
            n_idx = IDX_W'(CNT_W'(r_idx) + CNT_W'(1));
        end else if (r_state == S_MISS && can_create) begin
            n_idx = IDX_W'(r_used);
        end
    end

    // working record: cleared or opened on a miss, folded on a hit, summed after the square
    always_comb begin
        n_rec = r_rec;
        case (r_state)
            S_MISS: begin
                n_rec = '0;
                if (can_create) begin
                    n_rec.healthy    = r_healthy;
                    n_rec.first_time = r_ts;
                    n_rec.last_time  = r_ts;
                    n_rec.updates    = 32'd1;
                    n_rec.min_p      = '1;
                end
            end
            S_LOAD: begin
                n_rec = r_stat_q;
                if (r_cmd == eps_pkg::CMD_UPDATE) begin
                    n_rec.healthy   = r_healthy;
                    n_rec.last_time = r_ts;
                    n_rec.updates   = r_stat_q.updates + 32'd1;
                    if (period_ok) begin
                        n_rec.intervals = r_stat_q.intervals + 32'd1;
                        if (period < r_stat_q.min_p) begin
                            n_rec.min_p = period;
                        end
                        if (period > r_stat_q.max_p) begin
                            n_rec.max_p = period;
                        end
                    end
                end
            end
            S_ACC: begin
                if (r_acc) begin
                    n_rec.sum    = r_rec.sum + ACC_W'(r_period);
                    n_rec.sq_sum = r_rec.sq_sum + r_sq;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    // Writes land in the emit cycle, and the next scan starts no earlier than
    // the cycle after, so no data read in the same cycle as a write is used.
    always_ff @(posedge i_clk) begin
        r_key_q  <= key_mem[n_idx];
        r_stat_q <= stat_mem[n_idx];
        if (key_we) begin
            key_mem[r_idx] <= r_key;
        end
        if (stat_we) begin
            stat_mem[r_idx] <= r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_write     <= 1'b0;
            r_create    <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_rec       <= n_rec;
            r_out_valid <= emit_fire || (r_out_valid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd     <= eps_pkg::t_cmd'(s_axis_tuser);
                        r_key     <= eps_pkg::canon_key(s_axis_tdata[KEY_W-1:0], KEY_BYTES);
                        r_healthy <= s_axis_tdata[KEY_W];
                        r_ts      <= s_axis_tdata[KEY_W+1 +: TS_W];
                        r_write   <= 1'b0;
                        r_create  <= 1'b0;
                        r_state   <= (r_used == '0) ? S_MISS : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // one key compare a cycle; the matching record is read next
                    if (key_hit) begin
                        r_state <= S_LOAD;
                    end else if (scan_last) begin
                        r_state <= S_MISS;
                    end
                end
                S_MISS: begin
                    if (r_cmd == eps_pkg::CMD_QUERY) begin
                        r_status <= eps_pkg::ST_QUERY_MISS;
                    end else if (r_used == CNT_W'(MAX_ENTRIES)) begin
                        r_status <= eps_pkg::ST_DROPPED;
                    end else begin
                        // open a new entry at the end of the table
                        r_status <= eps_pkg::ST_CREATED;
                        r_used   <= r_used + CNT_W'(1);
                        r_write  <= 1'b1;
                        r_create <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_LOAD: begin
                    if (r_cmd == eps_pkg::CMD_QUERY) begin
                        r_status <= eps_pkg::ST_QUERY_HIT;
                        r_state  <= S_EMIT;
                    end else begin
                        // fold in everything but the sums; sums wait for the square
                        r_status <= eps_pkg::ST_UPDATED;
                        r_write  <= 1'b1;
                        r_period <= period;
                        r_acc    <= period_ok;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sq    <= sq_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free, then write back
                    if (emit_fire) begin
                        r_out_status <= r_status;
                        r_out_rec    <= r_rec;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(eps_pkg::OUT_DATA_W - eps_pkg::OUT_BITS)'(0), r_out_rec};

    // the table never grows past its depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // a scan only reads entries in use
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> CNT_W'(r_idx) < r_used)
        else $error("key scan past last entry");

    // a drop happens only with a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && r_status == eps_pkg::ST_DROPPED |-> r_used == CNT_W'(MAX_ENTRIES))
        else $error("update dropped with room left");

    // queries leave the entry count alone
    a_query_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && (r_status == eps_pkg::ST_QUERY_HIT ||
                      r_status == eps_pkg::ST_QUERY_MISS) |=> $stable(r_used))
        else $error("query changed the table");

    // only a creation writes the key memory
    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> r_status == eps_pkg::ST_CREATED && r_write)
        else $error("key write without creation");

endmodule
